FILE: hdl/md5hs_pkg.sv
// Shared types, constants and round tables for the MD5 streaming hash block.
// No dependencies; every other file of the block imports this package.
package md5hs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0] waddr_t;
  typedef logic [3:0][31:0] cv_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;

  localparam word_t PAD_BYTE = 32'h00000080;
  localparam waddr_t LEN_POS = 4'd14;
  localparam waddr_t LAST_POS = 4'd15;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic done;
    logic busy;
  } core_stat_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_PRIME,
    CORE_ROUND,
    CORE_FINAL
  } core_state_t;

  typedef enum logic [2:0] {
    ST_IN,
    ST_PAD80,
    ST_PAD,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_COMP,
    ST_OUT
  } seq_state_t;

  // Message word used by a round.
  function automatic waddr_t msg_index(input logic [5:0] r);
    waddr_t lo;
    waddr_t idx;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = waddr_t'(4'd5 * lo + 4'd1);
      2'd2:    idx = waddr_t'(4'd3 * lo + 4'd5);
      default: idx = waddr_t'(4'd7 * lo);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic word_t round_const(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/md5hs_msgbuf.sv
// Sixteen-word block buffer: one write port, one read port with registered data.
// Depends on md5hs_pkg for the word and address types.
module md5hs_msgbuf (
  input  logic              clk,
  input  logic              we,
  input  md5hs_pkg::waddr_t waddr,
  input  md5hs_pkg::word_t  wdata,
  input  md5hs_pkg::waddr_t raddr,
  output md5hs_pkg::word_t  rdata
);
  import md5hs_pkg::*;

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/md5hs_core.sv
// MD5 compression core: one round per cycle over the block buffer, plus the
// chaining value registers. Depends on md5hs_pkg for tables and types.
module md5hs_core (
  input  logic                  clk,
  input  logic                  rst,
  input  md5hs_pkg::core_ctrl_t ctrl,
  output md5hs_pkg::core_stat_t stat,
  output md5hs_pkg::waddr_t     raddr,
  input  md5hs_pkg::word_t      rdata,
  output md5hs_pkg::cv_t        cv
);
  import md5hs_pkg::*;

  core_state_t state, state_next;
  logic [5:0] rnd;
  word_t ra, rb, rc, rd;
  word_t f_val;
  word_t sum;
  word_t new_b;
  logic [63:0] dbl;
  logic [4:0] s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.done = 1'b0;
    stat.busy = (state != CORE_IDLE);
    raddr = msg_index(6'(rnd + 6'd1));
    case (state)
      CORE_IDLE: begin
        if (ctrl.start) begin
          state_next = CORE_PRIME;
        end
      end
      CORE_PRIME: begin
        raddr = msg_index(6'd0);
        state_next = CORE_ROUND;
      end
      CORE_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = CORE_FINAL;
        end
      end
      CORE_FINAL: begin
        stat.done = 1'b1;
        state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_comb begin
    case (rnd[5:4])
      2'd0:    f_val = (rb & rc) | (~rb & rd);
      2'd1:    f_val = (rb & rd) | (rc & ~rd);
      2'd2:    f_val = rb ^ rc ^ rd;
      default: f_val = rc ^ (rb | ~rd);
    endcase
    sum = ra + f_val + rdata + round_const(rnd);
    s = rot_amount(rnd);
    // Right shift of the doubled word by 32 - s leaves the left rotation below.
    dbl = {sum, sum} >> (6'd32 - {1'b0, s});
    new_b = rb + dbl[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
      ra <= '0;
      rb <= '0;
      rc <= '0;
      rd <= '0;
      cv <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      case (state)
        CORE_PRIME: begin
          rnd <= '0;
          ra <= cv[0];
          rb <= cv[1];
          rc <= cv[2];
          rd <= cv[3];
        end
        CORE_ROUND: begin
          rnd <= 6'(rnd + 6'd1);
          ra <= rd;
          rb <= new_b;
          rc <= rb;
          rd <= rc;
        end
        CORE_FINAL: begin
          cv[0] <= cv[0] + ra;
          cv[1] <= cv[1] + rb;
          cv[2] <= cv[2] + rc;
          cv[3] <= cv[3] + rd;
        end
        default: begin
          if (ctrl.init) begin
            cv <= {IV_D, IV_C, IV_B, IV_A};
          end
        end
      endcase
    end
  end

endmodule

FILE: hdl/md5_hash_stream.sv
// MD5 over a stream of 32-bit little-endian message words.
// Input channel: message_word, valid_bytes and last_word with msg_valid and
// msg_stall; a request is taken when msg_valid is high and msg_stall low.
// Output channel: digest_word, digest_index and digest_last with digest_valid
// and digest_stall; four requests per message, A first, digest_last on D.
// Each input word is written to the block buffer when it is taken. The
// sixteenth word of a block starts the compression core, which fills its
// working registers from the chaining value, runs the 64 rounds and then
// updates the chaining value. msg_stall is high while the core runs, while
// padding is written and while the digest is out. After the last word the
// block writes the padding and the bit length into the buffer and runs one
// or two more compressions before the digest is shown. The digest stays on
// the port while digest_stall is high; after D is taken the chaining value,
// length and word position are back at their initial values. Reset (rst,
// synchronous) sets the same initial state; the buffer contents are not
// cleared.
// Depends on md5hs_pkg, md5hs_msgbuf and md5hs_core.
module md5_hash_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  digest_index,
  output logic        digest_last
);
  import md5hs_pkg::*;

  seq_state_t state, state_next;
  seq_state_t ret, ret_next;
  waddr_t pos;
  logic [63:0] bit_len, bit_len_next;
  logic [1:0] idx;

  logic push;
  word_t push_data;
  seq_state_t after;
  logic [2:0] nbytes;
  word_t tail_word;
  logic in_take;
  logic out_take;

  core_ctrl_t cctrl;
  core_stat_t cstat;
  waddr_t raddr;
  word_t rdata;
  cv_t cv;

  md5hs_msgbuf u_buf (
    .clk   (clk),
    .we    (push),
    .waddr (pos),
    .wdata (push_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  md5hs_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cctrl),
    .stat  (cstat),
    .raddr (raddr),
    .rdata (rdata),
    .cv    (cv)
  );

  assign in_take = msg_valid && !msg_stall;
  assign out_take = digest_valid && !digest_stall;

  // Count of bytes used from the request; only the last word may be short.
  always_comb begin
    if (!last_word || valid_bytes > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = valid_bytes;
    end
    case (nbytes)
      3'd0:    tail_word = PAD_BYTE;
      3'd1:    tail_word = {16'h0000, 8'h80, message_word[7:0]};
      3'd2:    tail_word = {8'h00, 8'h80, message_word[15:0]};
      3'd3:    tail_word = {8'h80, message_word[23:0]};
      default: tail_word = message_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
      ret <= ST_IN;
      pos <= '0;
      bit_len <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      bit_len <= bit_len_next;
      if (push) begin
        pos <= 4'(pos + 4'd1);
      end
      if (out_take) begin
        idx <= 2'(idx + 2'd1);
      end
    end
  end

  always_comb begin
    push = 1'b0;
    push_data = message_word;
    after = state;
    ret_next = ret;
    bit_len_next = bit_len;
    cctrl.start = 1'b0;
    cctrl.init = 1'b0;
    msg_stall = (state != ST_IN);
    digest_valid = (state == ST_OUT);
    case (state)
      ST_IN: begin
        if (msg_valid) begin
          push = 1'b1;
          bit_len_next = bit_len + {58'd0, nbytes, 3'b000};
          if (!last_word) begin
            after = ST_IN;
          end else if (nbytes == 3'd4) begin
            after = ST_PAD80;
          end else begin
            push_data = tail_word;
            after = ST_PAD;
          end
        end
      end
      ST_PAD80: begin
        push = 1'b1;
        push_data = PAD_BYTE;
        after = ST_PAD;
      end
      ST_PAD: begin
        if (pos == LEN_POS) begin
          after = ST_LEN_LO;
        end else begin
          push = 1'b1;
          push_data = '0;
          after = ST_PAD;
        end
      end
      ST_LEN_LO: begin
        push = 1'b1;
        push_data = bit_len[31:0];
        after = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        push = 1'b1;
        push_data = bit_len[63:32];
        after = ST_OUT;
      end
      ST_COMP: begin
        if (cstat.done) begin
          after = ret;
        end
      end
      ST_OUT: begin
        if (out_take && idx == 2'd3) begin
          cctrl.init = 1'b1;
          bit_len_next = '0;
          after = ST_IN;
        end
      end
      default: after = ST_IN;
    endcase

    // Writing the final word of a block hands the buffer to the core.
    state_next = after;
    if (push && pos == LAST_POS) begin
      cctrl.start = 1'b1;
      ret_next = after;
      state_next = ST_COMP;
    end
  end

  assign digest_word = cv[idx];
  assign digest_index = idx;
  assign digest_last = (idx == 2'd3);

endmodule
